@@ hdl/ttbs_pkg.sv @@
// ----------------------------------------------------------------------------
// ttbs_pkg: shared types and constants for the tick timer bank scheduler
// Command codes, slot counts and the record that moves along the slot chain.
// ----------------------------------------------------------------------------
package ttbs_pkg;

    localparam int TASK_SLOTS  = 8;
    localparam int TIMER_SLOTS = 4;
    localparam int SOFT_TIMERS = 4;

    // chain length: every slot kind shares one ring of cells
    localparam int CELLS   = TASK_SLOTS + TIMER_SLOTS + SOFT_TIMERS;
    localparam int CELL_W  = $clog2(CELLS);
    localparam int TCNT_W  = $clog2(TASK_SLOTS + 1);
    localparam int MCNT_W  = $clog2(TIMER_SLOTS + 1);

    typedef enum logic [3:0] {
        FN_TICK    = 4'd0,
        FN_MK_TASK = 4'd1,
        FN_RESUME  = 4'd2,
        FN_HOLD    = 4'd3,
        FN_MK_TMR  = 4'd4,
        FN_RESTART = 4'd5,
        FN_STOP    = 4'd6,
        FN_SOFT    = 4'd7,
        FN_COLLECT = 4'd8,
        FN_QUERY   = 4'd9,
        FN_NONE    = 4'd15     // request that leaves every slot alone
    } func_t;

    typedef enum logic [1:0] {
        KIND_TASK  = 2'd0,
        KIND_TIMER = 2'd1,
        KIND_SOFT  = 2'd2
    } kind_t;

    // state of one slot; flags mean per kind (task/timer/soft)
    typedef struct packed {
        kind_t       kind;
        logic [3:0]  id;
        logic        used;     // created (soft: always)
        logic        mode;     // task sync / timer periodic
        logic        run;      // task ready / timer running
        logic        pend;
        logic [15:0] period;
        logic [15:0] cnt;      // ticks, or remaining for soft
    } slot_t;

    // request broadcast to the cell at the chain head
    typedef struct packed {
        logic [3:0]  func;
        logic [3:0]  index;
        logic [15:0] period;
        logic        periodic;
        logic [15:0] soft_time;
        logic [3:0]  new_id;   // handle for a create
    } req_t;

    // what a cell reports back to the sequencer
    typedef struct packed {
        logic        fired;    // collect produced a result
        logic        done;     // soft timer named by the request is at zero
    } rpt_t;

endpackage

@@ hdl/ttbs_cell.sv @@
// ----------------------------------------------------------------------------
// ttbs_cell: one slot of the rotating slot chain
// Applies the current request to the slot at the head and passes it on.
// ----------------------------------------------------------------------------
module ttbs_cell import ttbs_pkg::*; (
    input  logic  aclk,
    input  logic  shift,
    input  logic  apply,
    input  req_t  req,
    input  slot_t slot_in,
    input  logic  load,
    input  slot_t load_val,
    output slot_t slot_out,
    output rpt_t  rpt
);

    slot_t slot_reg;
    slot_t upd;

    // apply the request to the incoming slot
    always_comb begin
        upd = slot_in;
        rpt = '0;
        if (apply) begin
            case (slot_in.kind)
                KIND_TASK: begin
                    if (req.func == FN_TICK && slot_in.used && slot_in.mode
                        && slot_in.run) begin
                        upd.cnt = slot_in.cnt + 16'd1;
                        if (upd.cnt >= slot_in.period) begin
                            upd.cnt  = '0;
                            upd.pend = 1'b1;
                        end
                    end
                    if (req.func == FN_MK_TASK && slot_in.id == req.new_id) begin
                        upd.used   = 1'b1;
                        upd.mode   = req.periodic;
                        upd.run    = 1'b1;
                        upd.pend   = 1'b0;
                        upd.cnt    = '0;
                        upd.period = req.period;
                    end
                    if ((req.func == FN_RESUME || req.func == FN_HOLD)
                        && slot_in.used && slot_in.id == req.index) begin
                        upd.run = (req.func == FN_RESUME);
                    end
                    if (req.func == FN_COLLECT && slot_in.used && slot_in.pend
                        && slot_in.run) begin
                        upd.pend  = 1'b0;
                        rpt.fired = 1'b1;
                    end
                end
                KIND_TIMER: begin
                    if (req.func == FN_TICK && slot_in.used && slot_in.run) begin
                        upd.cnt = slot_in.cnt + 16'd1;
                        if (upd.cnt >= slot_in.period) begin
                            upd.cnt  = '0;
                            upd.pend = 1'b1;
                            upd.run  = slot_in.mode;
                        end
                    end
                    if (req.func == FN_MK_TMR && slot_in.id == req.new_id) begin
                        upd.used   = 1'b1;
                        upd.mode   = req.periodic;
                        upd.run    = 1'b0;
                        upd.pend   = 1'b0;
                        upd.cnt    = '0;
                        upd.period = req.period;
                    end
                    if (slot_in.used && slot_in.id == req.index) begin
                        if (req.func == FN_RESTART) begin
                            upd.cnt = '0;
                            upd.run = 1'b1;
                        end
                        if (req.func == FN_STOP) begin
                            upd.run = 1'b0;
                        end
                    end
                    if (req.func == FN_COLLECT && slot_in.used && slot_in.pend) begin
                        upd.pend  = 1'b0;
                        rpt.fired = 1'b1;
                    end
                end
                default: begin
                    if (req.func == FN_TICK && slot_in.cnt != 16'd0) begin
                        upd.cnt = slot_in.cnt - 16'd1;
                    end
                    if (slot_in.id == req.index) begin
                        if (req.func == FN_SOFT) begin
                            upd.cnt = req.soft_time;
                        end
                        rpt.done = (slot_in.cnt == 16'd0);
                    end
                end
            endcase
        end
    end

    // load, hold or advance the slot
    always_ff @(posedge aclk) begin
        if (load) begin
            slot_reg <= load_val;
        end else if (shift) begin
            slot_reg <= upd;
        end
    end

    assign slot_out = slot_reg;

endmodule

@@ hdl/tick_timer_bank_scheduler.sv @@
// ----------------------------------------------------------------------------
// tick_timer_bank_scheduler: tick-driven task, timer and soft timer bank
// Command sequencer around a rotating chain of slot cells.
// ----------------------------------------------------------------------------
// All 16 slots (8 tasks, 4 timers, 4 soft timers) sit in a ring of cells that
// rotates one place per cycle while not stalled. Every command takes one full
// revolution of the ring, then loads its last result into the output register,
// and the next request is taken only once that result has been loaded.
// Collect results come out as the chain carries each fired slot past the
// head, tasks first then timers, in handle order; while a pending result waits
// and the output register is still full, a further fired slot at the head stops
// the ring, so a stalled receiver lengthens the command. The ring loads its
// slot identities after reset before the first request is taken.
module tick_timer_bank_scheduler import ttbs_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // index[3:0], period[19:4], periodic[20], soft_time[36:21]
    input  logic [39:0] s_tdata,
    // func[3:0]
    input  logic [3:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // status[0], handle[4:1], fired_index[8:5], soft_done[9], system_tick[25:10]
    output logic [31:0] m_tdata,
    // fired_valid[0], fired_kind[1]
    output logic [1:0]  m_tuser,
    output logic        m_tlast
);

    typedef enum logic [1:0] {ST_INIT, ST_IDLE, ST_RUN, ST_FLUSH} state_t;

    state_t              state_reg;
    logic [CELL_W-1:0]   pos_reg;
    req_t                req_reg;
    logic [TCNT_W-1:0]   tcnt_reg;
    logic [MCNT_W-1:0]   mcnt_reg;
    logic [15:0]         tick_reg;
    logic                status_reg;
    logic                done_reg;
    logic                ov_reg;       // output holding valid
    logic [31:0]         od_reg;
    logic [1:0]          ou_reg;
    logic                ol_reg;
    logic                pv_reg;       // pending collect result
    logic [4:0]          pf_reg;       // kind + index of pending result

    slot_t chain [CELLS];
    slot_t init_val;
    rpt_t  rpt;
    logic  run;
    logic  stall;
    logic  shift;
    logic  loading;
    logic  out_free;
    slot_t head;

    assign head     = chain[CELLS-1];
    assign loading  = (state_reg == ST_INIT);
    assign run      = (state_reg == ST_RUN);
    assign out_free = !ov_reg || m_tready;
    // hold the ring while a second fired slot has nowhere to go
    assign stall    = rpt.fired && pv_reg && !out_free;
    assign shift    = run && !stall;

    // identity of the slot that enters the chain during init
    always_comb begin
        init_val = '0;
        if (pos_reg < CELL_W'(TASK_SLOTS)) begin
            init_val.kind = KIND_TASK;
            init_val.id   = 4'(pos_reg);
        end else if (pos_reg < CELL_W'(TASK_SLOTS + TIMER_SLOTS)) begin
            init_val.kind = KIND_TIMER;
            init_val.id   = 4'(pos_reg - CELL_W'(TASK_SLOTS));
        end else begin
            init_val.kind = KIND_SOFT;
            init_val.id   = 4'(pos_reg - CELL_W'(TASK_SLOTS + TIMER_SLOTS));
            init_val.used = 1'b1;
        end
    end

    // ring of cells: head cell applies the request, the rest just rotate
    for (genvar g = 0; g < CELLS; g++) begin : g_cell
        slot_t prev;
        rpt_t  r;
        if (g == 0) begin : g_head
            assign prev = head;
        end else begin : g_body
            assign prev = chain[g-1];
        end
        ttbs_cell u_cell (
            .aclk     (aclk),
            .shift    (shift || loading),
            .apply    (g == 0 && run),
            .req      (req_reg),
            .slot_in  ((g == 0 && loading) ? init_val : prev),
            .load     (1'b0),
            .load_val ('0),
            .slot_out (chain[g]),
            .rpt      (r)
        );
        if (g == 0) begin : g_rpt
            assign rpt = r;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
            pos_reg   <= '0;
            tcnt_reg  <= '0;
            mcnt_reg  <= '0;
            tick_reg  <= '0;
            ov_reg    <= 1'b0;
            pv_reg    <= 1'b0;
        end else begin
            if (ov_reg && m_tready) begin
                ov_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_INIT: begin
                    pos_reg <= pos_reg + 1'b1;
                    if (pos_reg == CELL_W'(CELLS - 1)) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (s_tvalid) begin
                        req_reg.func      <= s_tuser;
                        req_reg.index     <= s_tdata[3:0];
                        req_reg.period    <= s_tdata[19:4];
                        req_reg.periodic  <= s_tdata[20];
                        req_reg.soft_time <= s_tdata[36:21];
                        status_reg <= 1'b0;
                        done_reg   <= 1'b0;
                        pos_reg    <= '0;
                        case (s_tuser)
                            FN_TICK: begin
                                tick_reg <= tick_reg + 16'd1;
                            end
                            FN_MK_TASK: begin
                                req_reg.new_id <= 4'(tcnt_reg);
                                if (tcnt_reg == TCNT_W'(TASK_SLOTS)) begin
                                    status_reg     <= 1'b1;
                                    req_reg.new_id <= 4'hF;
                                    req_reg.func   <= FN_NONE;
                                end else begin
                                    tcnt_reg <= tcnt_reg + 1'b1;
                                end
                            end
                            FN_MK_TMR: begin
                                req_reg.new_id <= 4'(mcnt_reg);
                                if (mcnt_reg == MCNT_W'(TIMER_SLOTS)) begin
                                    status_reg     <= 1'b1;
                                    req_reg.new_id <= 4'hF;
                                    req_reg.func   <= FN_NONE;
                                end else begin
                                    mcnt_reg <= mcnt_reg + 1'b1;
                                end
                            end
                            FN_RESUME, FN_HOLD: begin
                                status_reg <= ({1'b0, s_tdata[3:0]} >=
                                               5'(tcnt_reg));
                            end
                            FN_RESTART, FN_STOP: begin
                                status_reg <= ({1'b0, s_tdata[3:0]} >=
                                               5'(mcnt_reg));
                            end
                            FN_SOFT, FN_QUERY: begin
                                status_reg <= ({1'b0, s_tdata[3:0]} >=
                                               5'(SOFT_TIMERS));
                            end
                            FN_COLLECT: begin
                            end
                            default: begin
                                status_reg <= 1'b1;
                            end
                        endcase
                        if (s_tuser != FN_MK_TASK && s_tuser != FN_MK_TMR) begin
                            req_reg.new_id <= 4'hF;
                        end
                        state_reg <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    // a fired slot becomes a pending result; wait if it can't go
                    if (!stall) begin
                        if (rpt.done && req_reg.func == FN_QUERY) begin
                            done_reg <= 1'b1;
                        end
                        if (rpt.fired) begin
                            if (pv_reg) begin
                                ov_reg <= 1'b1;
                                od_reg <= {6'd0, tick_reg, 1'b0, pf_reg[3:0],
                                           4'd0, 1'b0};
                                ou_reg <= {pf_reg[4], 1'b1};
                                ol_reg <= 1'b0;
                            end
                            pv_reg <= 1'b1;
                            pf_reg <= {(head.kind == KIND_TIMER), head.id};
                        end
                        pos_reg <= pos_reg + 1'b1;
                        if (pos_reg == CELL_W'(CELLS - 1)) begin
                            state_reg <= ST_FLUSH;
                        end
                    end
                end
                default: begin
                    if (out_free) begin
                        ov_reg    <= 1'b1;
                        ol_reg    <= 1'b1;
                        pv_reg    <= 1'b0;
                        state_reg <= ST_IDLE;
                        if (pv_reg) begin
                            od_reg <= {6'd0, tick_reg, 1'b0, pf_reg[3:0],
                                       4'd0, 1'b0};
                            ou_reg <= {pf_reg[4], 1'b1};
                        end else if (req_reg.func == FN_COLLECT) begin
                            od_reg <= {6'd0, tick_reg, 10'd0};
                            ou_reg <= 2'b00;
                        end else begin
                            od_reg <= {6'd0, tick_reg,
                                       done_reg && !status_reg, 4'd0,
                                       ((req_reg.func == FN_MK_TASK ||
                                         req_reg.func == FN_MK_TMR) && !status_reg)
                                           ? req_reg.new_id : 4'd0,
                                       status_reg};
                            ou_reg <= 2'b00;
                        end
                    end
                end
            endcase
        end
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = od_reg;
    assign m_tuser  = ou_reg;
    assign m_tlast  = ol_reg;

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: tick timer bank scheduler
// Drives task, timer and soft timer commands, tracks the scheduler state in a
// local model and compares every response beat field by field in order.
// ----------------------------------------------------------------------------
module testbench;
    import ttbs_pkg::*;

    typedef struct packed {
        logic        status;
        logic [3:0]  handle;
        logic        fired_valid;
        logic        fired_kind;
        logic [3:0]  fired_index;
        logic        soft_done;
        logic [15:0] system_tick;
        logic        last;
    } resp_t;

    // scheduler shadow and the queue of responses it predicts
    class sched_scoreboard;
        int unsigned n_tasks;
        logic [15:0] task_per [TASK_SLOTS];
        logic        task_sync [TASK_SLOTS];
        logic        task_rdy [TASK_SLOTS];
        logic [15:0] task_cnt [TASK_SLOTS];
        logic        task_pend [TASK_SLOTS];
        int unsigned n_timers;
        logic [15:0] tmr_per [TIMER_SLOTS];
        logic        tmr_per_mode [TIMER_SLOTS];
        logic        tmr_run [TIMER_SLOTS];
        logic [15:0] tmr_cnt [TIMER_SLOTS];
        logic        tmr_pend [TIMER_SLOTS];
        logic [15:0] soft_left [SOFT_TIMERS];
        logic [15:0] sys_tick;
        resp_t       pending_resp [$];
        int          errors;

        function new();
            n_tasks = 0;
            n_timers = 0;
            sys_tick = 0;
            errors = 0;
            foreach (task_per[i]) begin
                task_per[i] = 0; task_sync[i] = 0; task_rdy[i] = 0;
                task_cnt[i] = 0; task_pend[i] = 0;
            end
            foreach (tmr_per[i]) begin
                tmr_per[i] = 0; tmr_per_mode[i] = 0; tmr_run[i] = 0;
                tmr_cnt[i] = 0; tmr_pend[i] = 0;
            end
            foreach (soft_left[i]) soft_left[i] = 0;
        endfunction

        function void push(logic st, logic [3:0] h, logic fv, logic fk,
                           logic [3:0] fi, logic sd, logic lst);
            resp_t r;
            r = '{st, h, fv, fk, fi, sd, sys_tick, lst};
            pending_resp.push_back(r);
        endfunction

        function void advance_tick();
            sys_tick = sys_tick + 16'd1;
            for (int i = 0; i < n_tasks; i++) begin
                if (task_sync[i] && task_rdy[i]) begin
                    task_cnt[i] = task_cnt[i] + 16'd1;
                    if (task_cnt[i] >= task_per[i]) begin
                        task_cnt[i] = 0;
                        task_pend[i] = 1;
                    end
                end
            end
            for (int i = 0; i < n_timers; i++) begin
                if (tmr_run[i]) begin
                    tmr_cnt[i] = tmr_cnt[i] + 16'd1;
                    if (tmr_cnt[i] >= tmr_per[i]) begin
                        tmr_pend[i] = 1;
                        tmr_cnt[i] = 0;
                        tmr_run[i] = tmr_per_mode[i];
                    end
                end
            end
            foreach (soft_left[i])
                if (soft_left[i] != 0) soft_left[i] = soft_left[i] - 16'd1;
        endfunction

        // note an accepted request and queue its responses
        function void note_request(logic [3:0] fn, logic [3:0] idx, logic [15:0] per,
                                   logic prd, logic [15:0] st_time);
            logic       st;
            logic [3:0] h;
            logic       sd;
            int         nfired;
            st = 0; h = 0; sd = 0; nfired = 0;
            case (fn)
                FN_TICK: advance_tick();
                FN_MK_TASK: begin
                    if (n_tasks < TASK_SLOTS) begin
                        task_per[n_tasks] = per; task_sync[n_tasks] = prd;
                        task_rdy[n_tasks] = 1; task_cnt[n_tasks] = 0;
                        task_pend[n_tasks] = 0; h = 4'(n_tasks); n_tasks++;
                    end else st = 1;
                end
                FN_RESUME, FN_HOLD: begin
                    if (idx < n_tasks) task_rdy[idx] = (fn == FN_RESUME);
                    else st = 1;
                end
                FN_MK_TMR: begin
                    if (n_timers < TIMER_SLOTS) begin
                        tmr_per[n_timers] = per; tmr_per_mode[n_timers] = prd;
                        tmr_run[n_timers] = 0; tmr_cnt[n_timers] = 0;
                        tmr_pend[n_timers] = 0; h = 4'(n_timers); n_timers++;
                    end else st = 1;
                end
                FN_RESTART: begin
                    if (idx < n_timers) begin
                        tmr_cnt[idx] = 0; tmr_run[idx] = 1;
                    end else st = 1;
                end
                FN_STOP: begin
                    if (idx < n_timers) tmr_run[idx] = 0;
                    else st = 1;
                end
                FN_SOFT: begin
                    if (idx < SOFT_TIMERS) soft_left[idx] = st_time;
                    else st = 1;
                end
                FN_COLLECT: begin
                    for (int i = 0; i < n_tasks; i++) begin
                        if (task_pend[i] && task_rdy[i]) begin
                            task_pend[i] = 0;
                            push(1'b0, 4'd0, 1'b1, 1'b0, 4'(i), 1'b0, 1'b0);
                            nfired++;
                        end
                    end
                    for (int i = 0; i < n_timers; i++) begin
                        if (tmr_pend[i]) begin
                            tmr_pend[i] = 0;
                            push(1'b0, 4'd0, 1'b1, 1'b1, 4'(i), 1'b0, 1'b0);
                            nfired++;
                        end
                    end
                    if (nfired == 0) push(0, 0, 0, 0, 0, 0, 1);
                    else pending_resp[$].last = 1;
                    return;
                end
                FN_QUERY: begin
                    if (idx < SOFT_TIMERS) sd = (soft_left[idx] == 0);
                    else st = 1;
                end
                default: st = 1;
            endcase
            push(st, h, 0, 0, 0, sd, 1);
        endfunction

        // compare one response beat with the oldest prediction
        function void check_response(resp_t got);
            resp_t exp_r;
            if (pending_resp.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected response %h", got);
                return;
            end
            exp_r = pending_resp.pop_front();
            if (got !== exp_r) begin
                errors++;
                if (errors <= 10)
                    $display("response mismatch: expected %h actual %h", exp_r, got);
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic [3:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    sched_scoreboard sb;
    int  idle_pct_in;
    int  idle_pct_out;
    int  hold_off;

    tick_timer_bank_scheduler i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast)
    );

    always begin
        aclk = 1'b0; #5;
        aclk = 1'b1; #5;
    end

    // drive one request, with a random gap before it
    task send_request(func_t fn, logic [3:0] idx, logic [15:0] per, logic prd,
                      logic [15:0] st_time);
        while ($urandom_range(99, 0) < idle_pct_in) @(negedge aclk);
        s_tvalid = 1'b1;
        s_tuser  = fn;
        s_tdata  = {3'd0, st_time, prd, per, idx};
        do @(posedge aclk); while (!s_tready);
        sb.note_request(fn, idx, per, prd, st_time);
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    task send_random_noise();
        logic [3:0] fn;
        fn = 4'($urandom_range(15, 0));
        send_request(func_t'(fn), 4'($urandom), 16'($urandom), 1'($urandom),
                     16'($urandom));
    endtask

    // mostly small periods so entries fire often
    function logic [15:0] pick_period();
        case ($urandom_range(9, 0))
            0: return 16'hFFFF;
            1: return 16'($urandom);
            default: return 16'($urandom_range(4, 0));
        endcase
    endfunction

    // receiver: random stalls, one long hold-off while the sender keeps going
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99, 0) >= idle_pct_out);
        end
    end

    // sample responses
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_response(resp_t'{m_tdata[0], m_tdata[4:1], m_tuser[0],
                                      m_tuser[1], m_tdata[8:5], m_tdata[9],
                                      m_tdata[25:10], m_tlast});
    end

    initial begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

    initial begin
        sb = new();
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        hold_off = 0;
        idle_pct_in = 28;
        idle_pct_out = 28;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: out of range handles on an empty bank, empty collect, unknown command, soft set and query
        send_request(FN_RESUME, 0, 0, 0, 0);
        send_request(FN_RESTART, 15, 0, 0, 0);
        send_request(FN_COLLECT, 0, 0, 0, 0);
        send_request(func_t'(4'd15), 4'hF, 16'hFFFF, 1, 16'hFFFF);
        send_request(FN_SOFT, 3, 0, 0, 16'hFFFF);
        send_request(FN_SOFT, 4, 0, 0, 1);
        send_request(FN_QUERY, 3, 0, 0, 0);
        send_request(FN_QUERY, 15, 0, 0, 0);
        // fill the task table, zero period, async task, then one too many
        for (int i = 0; i < TASK_SLOTS + 1; i++)
            send_request(FN_MK_TASK, 0, (i == 1) ? 16'hFFFF : 16'(i % 3),
                         (i != 2), 0);
        for (int i = 0; i < TIMER_SLOTS + 1; i++)
            send_request(FN_MK_TMR, 0, 16'(i), i[0], 0);
        send_request(FN_RESTART, 0, 0, 0, 0);
        send_request(FN_RESTART, 1, 0, 0, 0);
        send_request(FN_HOLD, 3, 0, 0, 0);
        send_request(FN_TICK, 0, 0, 0, 0);
        send_request(FN_TICK, 0, 0, 0, 0);
        send_request(FN_COLLECT, 0, 0, 0, 0);
        send_request(FN_STOP, 0, 0, 0, 0);
        send_request(FN_RESUME, 3, 0, 0, 0);
        send_request(FN_COLLECT, 0, 0, 0, 0);

        // receiver stalls long while requests keep coming
        idle_pct_in = 0;
        @(negedge aclk);
        hold_off <= 400;
        for (int i = 0; i < 12; i++) send_request(FN_TICK, 0, 0, 0, 0);
        send_request(FN_COLLECT, 0, 0, 0, 0);

        // random: weighted toward ticks and collects, with a calm stretch
        for (int i = 0; i < 285; i++) begin
            if (i == 60) begin idle_pct_in = 0; idle_pct_out = 0; end
            if (i == 120) begin idle_pct_in = 28; idle_pct_out = 28; end
            case ($urandom_range(19, 0))
                0, 1, 2, 3, 4, 5, 6: send_request(FN_TICK, 4'($urandom), 16'($urandom),
                                                  1'($urandom), 16'($urandom));
                7, 8, 9: send_request(FN_COLLECT, 4'($urandom), 16'($urandom),
                                      1'($urandom), 16'($urandom));
                10: send_request(FN_RESTART, 4'($urandom_range(4, 0)), 0, 0, 0);
                11: send_request(FN_STOP, 4'($urandom_range(4, 0)), 0, 0, 0);
                12: send_request(FN_HOLD, 4'($urandom_range(8, 0)), 0, 0, 0);
                13: send_request(FN_RESUME, 4'($urandom_range(8, 0)), 0, 0, 0);
                14: send_request(FN_SOFT, 4'($urandom_range(5, 0)), 0, 0,
                                 ($urandom_range(3, 0) == 0) ? 16'($urandom) :
                                 16'($urandom_range(5, 0)));
                15: send_request(FN_QUERY, 4'($urandom_range(5, 0)), 0, 0, 0);
                16: send_request(FN_MK_TASK, 0, pick_period(),
                                 1'($urandom_range(1, 0)), 0);
                17: send_request(FN_MK_TMR, 0, pick_period(),
                                 1'($urandom_range(1, 0)), 0);
                default: send_random_noise();
            endcase
        end

        while (sb.pending_resp.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (sb.errors == 0 && sb.pending_resp.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
